// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the receiver RTL.
// Standalone header; the including module must declare clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/hfr_pkg.sv
// Shared types, codes and the CRC-8 step for the heartbeat frame receiver.
// No dependencies.
package hfr_pkg;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        parity_error;
    logic [31:0] current_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  rx_status;
    logic [7:0]  fault_mask;
    logic [31:0] heartbeat_tick;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_ABSORB = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2,
    ST_PARITY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_SEQ  = 3'd2,
    PH_CMD  = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SYNC    = 1'd0,
    CFG_HB_TYPE = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] heartbeat_type;
  } cfg_t;

  localparam logic [7:0] SYNC_RESET    = 8'hAA;
  localparam logic [7:0] HB_TYPE_RESET = 8'h01;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] CRC_INIT      = 8'h00;

  // One byte through CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/heartbeat_frame_receiver_unit.sv
// Top level of the heartbeat frame receiver.
// Depends on hfr_pkg, hfr_cfg_regs, hfr_in_stage, hfr_frame_core, hfr_out_stage and assert_macros.svh.
//
//   channel   signals                                 direction
//   item      item_valid, item_stall, item            in  (byte, parity flag, tick)
//   result    result_valid, result_stall, result      out (status, fault mask, tick)
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in  (register writes)
//
// One byte is accepted per cycle while item_stall is low.
// The byte register feeds the phase/CRC logic, which writes the result register.
// Reset is synchronous; configuration writes take effect next cycle.
// A stalled result holds its register; the byte register then holds one more byte
// before item_stall rises.
module heartbeat_frame_receiver_unit #(
  parameter int TICK_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  hfr_pkg::in_item_t                item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output hfr_pkg::out_item_t               result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hfr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);
  import hfr_pkg::*;

  cfg_t      cfg;
  in_item_t  held;
  out_item_t next_result;
  logic      full;
  logic      advance;
  logic      take;

  assign take = full && advance;

  hfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .full       (full),
    .held       (held)
  );

  hfr_frame_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (held),
    .cfg    (cfg),
    .result (next_result)
  );

  hfr_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .in_full      (full),
    .next_result  (next_result),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_stall_needs_result, item_stall |-> result_valid && result_stall, "input stalled without a blocked result")

endmodule

// File: hw/rtl/hfr_cfg_regs.sv
// Configuration registers: sync byte and heartbeat type code.
// Depends on hfr_pkg.
module hfr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hfr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  output hfr_pkg::cfg_t                    cfg
);
  import hfr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value     <= SYNC_RESET;
      cfg.heartbeat_type <= HB_TYPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC:    cfg.sync_value     <= cfg_data;
        CFG_HB_TYPE: cfg.heartbeat_type <= cfg_data;
      endcase
    end
  end

endmodule

// File: hw/rtl/hfr_in_stage.sv
// Input register: holds one received byte until the frame core consumes it.
// Depends on hfr_pkg.
module hfr_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  hfr_pkg::in_item_t item,
  input  logic              advance,
  output logic              full,
  output hfr_pkg::in_item_t held
);
  import hfr_pkg::*;

  logic load;

  // Stall only while a held byte cannot move on this cycle.
  assign item_stall = full && !advance;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

endmodule

// File: hw/rtl/hfr_frame_core.sv
// Frame hunter: phase machine, running CRC-8 and the fault/tick stores.
// Depends on hfr_pkg and assert_macros.svh.
module hfr_frame_core #(
  parameter int TICK_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  hfr_pkg::in_item_t  item,
  input  hfr_pkg::cfg_t      cfg,
  output hfr_pkg::out_item_t result
);
  import hfr_pkg::*;

  phase_t               phase, phase_next;
  logic [7:0]           running_crc, running_crc_next;
  logic [7:0]           frame_type, frame_type_next;
  logic [7:0]           command_byte, command_byte_next;
  logic [7:0]           fault_store, fault_store_next;
  logic [TICK_BITS-1:0] tick_store, tick_store_next;
  status_t              status;
  logic [7:0]           crc_step;
  logic                 frame_good;
  logic [63:0]          tick_wide;
  logic [63:0]          store_wide;

  assign crc_step   = crc8_feed(running_crc, item.rx_byte);
  assign frame_good = (frame_type == cfg.heartbeat_type) && (running_crc == item.rx_byte);
  assign tick_wide  = 64'(item.current_tick);

  // Next phase.
  always_comb begin
    phase_next = PH_HUNT;
    if (!item.parity_error) begin
      unique case (phase)
        PH_HUNT: phase_next = (item.rx_byte == cfg.sync_value) ? PH_TYPE : PH_HUNT;
        PH_TYPE: phase_next = PH_SEQ;
        PH_SEQ:  phase_next = PH_CMD;
        PH_CMD:  phase_next = PH_CRC;
        PH_CRC:  phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // Status, CRC and stores.
  always_comb begin
    status            = ST_ABSORB;
    running_crc_next  = CRC_INIT;
    frame_type_next   = frame_type;
    command_byte_next = command_byte;
    fault_store_next  = fault_store;
    tick_store_next   = tick_store;
    if (item.parity_error) begin
      status = ST_PARITY;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          running_crc_next = (item.rx_byte == cfg.sync_value) ? crc_step : running_crc;
        end
        PH_TYPE: begin
          frame_type_next  = item.rx_byte;
          running_crc_next = crc_step;
        end
        PH_SEQ: begin
          running_crc_next = crc_step;
        end
        PH_CMD: begin
          command_byte_next = item.rx_byte;
          running_crc_next  = crc_step;
        end
        PH_CRC: begin
          if (frame_good) begin
            status           = ST_ACCEPT;
            fault_store_next = command_byte;
            tick_store_next  = tick_wide[TICK_BITS-1:0];
          end else begin
            status = ST_REJECT;
          end
        end
        default: begin
          status = ST_ABSORB;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      running_crc  <= CRC_INIT;
      frame_type   <= '0;
      command_byte <= '0;
      fault_store  <= '0;
      tick_store   <= '0;
    end else if (take) begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      frame_type   <= frame_type_next;
      command_byte <= command_byte_next;
      fault_store  <= fault_store_next;
      tick_store   <= tick_store_next;
    end
  end

  assign store_wide = 64'(tick_store_next);

  assign result.rx_status      = status;
  assign result.fault_mask     = fault_store_next;
  assign result.heartbeat_tick = store_wide[31:0];

`include "assert_macros.svh"

  `ASSERT_CLK(a_accept_loads_mask, take && status == ST_ACCEPT |=> fault_store == $past(command_byte), "accepted frame did not load the fault mask")
  `ASSERT_CLK(a_parity_rehunts, take && item.parity_error |=> phase == PH_HUNT && running_crc == CRC_INIT, "parity error did not restart the hunt")

endmodule

// File: hw/rtl/hfr_out_stage.sv
// Result register: holds one result until the consumer takes it.
// Depends on hfr_pkg.
module hfr_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_full,
  input  hfr_pkg::out_item_t next_result,
  output logic               advance,
  output logic               result_valid,
  input  logic               result_stall,
  output hfr_pkg::out_item_t result
);
  import hfr_pkg::*;

  // The register may refill whenever it is empty or being drained.
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      result <= next_result;
    end
  end

endmodule
